[hw/rtl/bpq_pkg.sv]
// Shared types, codes and sizes for the bounded priority queue.
package bpq_pkg;

  localparam int DEPTH    = 8;
  localparam int CNT_W    = $clog2(DEPTH + 1);
  localparam int DATA_W   = 32;
  localparam int PRIO_W   = 8;
  localparam int OCC_W    = 4;
  localparam int STATUS_W = 2;

  localparam int IN_TDATA_W  = ((DATA_W + PRIO_W + 7) / 8) * 8;
  localparam int IN_PAD_W    = IN_TDATA_W - DATA_W - PRIO_W;
  localparam int OUT_TDATA_W = ((DATA_W + PRIO_W + OCC_W + 7) / 8) * 8;
  localparam int OUT_PAD_W   = OUT_TDATA_W - DATA_W - PRIO_W - OCC_W;

  localparam logic KIND_ENQ = 1'b0;
  localparam logic KIND_DEQ = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_PUSH,
    OP_POP,
    OP_REFUSE_FULL,
    OP_REFUSE_EMPTY
  } op_e;

  typedef struct packed {
    op_e op;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } stat_t;

endpackage

[hw/rtl/bpq_ctrl.sv]
// Handshake controller: accepts requests, picks the operation, owns result valid.
module bpq_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_valid_i,
  input  logic          s_kind_i,
  output logic          s_ready_o,
  output logic          m_valid_o,
  input  logic          m_ready_i,
  input  bpq_pkg::stat_t stat_i,
  output bpq_pkg::cmd_t  cmd_o
);
  import bpq_pkg::*;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_HOLD = 1'b1;

  logic state_q, state_d;
  logic in_fire;

  // A held result that leaves this cycle frees the output register.
  assign s_ready_o = (state_q == S_IDLE) | m_ready_i;
  assign in_fire   = s_valid_i & s_ready_o;
  assign m_valid_o = (state_q == S_HOLD);

  always_comb begin
    state_d = state_q;
    if (in_fire) begin
      state_d = S_HOLD;
    end else if (m_ready_i) begin
      state_d = S_IDLE;
    end
  end

  always_comb begin
    cmd_o.op = OP_NONE;
    if (in_fire) begin
      case (s_kind_i)
        KIND_ENQ: cmd_o.op = stat_i.full ? OP_REFUSE_FULL : OP_PUSH;
        KIND_DEQ: cmd_o.op = stat_i.empty ? OP_REFUSE_EMPTY : OP_POP;
        default:  cmd_o.op = OP_NONE;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

[hw/rtl/bpq_datapath.sv]
// Sorted row of compare-and-shift cells, entry count and result register.
module bpq_datapath (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  bpq_pkg::cmd_t                cmd_i,
  input  logic [bpq_pkg::DATA_W-1:0]   in_data_i,
  input  logic [bpq_pkg::PRIO_W-1:0]   in_prio_i,
  output bpq_pkg::stat_t               stat_o,
  output logic [bpq_pkg::DATA_W-1:0]   res_data_o,
  output logic [bpq_pkg::PRIO_W-1:0]   res_prio_o,
  output logic [bpq_pkg::STATUS_W-1:0] res_status_o,
  output logic [bpq_pkg::OCC_W-1:0]    res_occ_o
);
  import bpq_pkg::*;

  logic [DATA_W-1:0]   data_q [DEPTH];
  logic [PRIO_W-1:0]   prio_q [DEPTH];
  logic [DEPTH-1:0]    ge;
  logic [CNT_W-1:0]    count_q, count_d;

  logic [DATA_W-1:0]   res_data_q;
  logic [PRIO_W-1:0]   res_prio_q;
  logic [STATUS_W-1:0] res_status_q;
  logic [OCC_W-1:0]    res_occ_q;

  assign stat_o.full  = (count_q == CNT_W'(DEPTH));
  assign stat_o.empty = (count_q == '0);

  // Held entries are sorted, so the ge vector is a run of ones from cell 0.
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      ge[i] = (CNT_W'(i) < count_q) && (prio_q[i] >= in_prio_i);
    end
  end

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [DATA_W-1:0] left_data, right_data;
    logic [PRIO_W-1:0] left_prio, right_prio;
    logic              left_ge;

    if (g == 0) begin : g_head
      assign left_data = in_data_i;
      assign left_prio = in_prio_i;
      assign left_ge   = 1'b1;
    end else begin : g_body
      assign left_data = data_q[g-1];
      assign left_prio = prio_q[g-1];
      assign left_ge   = ge[g-1];
    end

    if (g == DEPTH - 1) begin : g_tail
      assign right_data = data_q[g];
      assign right_prio = prio_q[g];
    end else begin : g_inner
      assign right_data = data_q[g+1];
      assign right_prio = prio_q[g+1];
    end

    // Keep, take the new entry, or shift from the neighbor.
    always_ff @(posedge clk_i) begin
      case (cmd_i.op)
        OP_PUSH: begin
          if (!ge[g]) begin
            if (left_ge) begin
              data_q[g] <= in_data_i;
              prio_q[g] <= in_prio_i;
            end else begin
              data_q[g] <= left_data;
              prio_q[g] <= left_prio;
            end
          end
        end
        OP_POP: begin
          data_q[g] <= right_data;
          prio_q[g] <= right_prio;
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (cmd_i.op)
      OP_PUSH: count_d = count_q + CNT_W'(1);
      OP_POP:  count_d = count_q - CNT_W'(1);
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op != OP_NONE) begin
      res_occ_q <= OCC_W'(count_d);
      case (cmd_i.op)
        OP_POP: begin
          res_data_q   <= data_q[0];
          res_prio_q   <= prio_q[0];
          res_status_q <= ST_OK;
        end
        OP_REFUSE_FULL: begin
          res_data_q   <= '0;
          res_prio_q   <= '0;
          res_status_q <= ST_OVERFLOW;
        end
        OP_REFUSE_EMPTY: begin
          res_data_q   <= '0;
          res_prio_q   <= '0;
          res_status_q <= ST_UNDERFLOW;
        end
        default: begin
          res_data_q   <= '0;
          res_prio_q   <= '0;
          res_status_q <= ST_OK;
        end
      endcase
    end
  end

  assign res_data_o   = res_data_q;
  assign res_prio_o   = res_prio_q;
  assign res_status_o = res_status_q;
  assign res_occ_o    = res_occ_q;

endmodule

[hw/rtl/bounded_priority_queue.sv]
// Top level of the bounded priority queue: controller plus cell datapath.
//
// Usage:
//   The slave stream carries one request per transfer. tuser selects the
//   operation (0 enqueue, 1 dequeue); tdata carries the data word and its
//   priority for an enqueue and is ignored for a dequeue.
//   The master stream returns exactly one result per request, in order:
//   the removed word and priority on a successful dequeue (zero otherwise),
//   the entry count after the operation, and a status code in tuser
//   (0 ok, 1 overflow on a full enqueue, 2 underflow on an empty dequeue).
//   Equal priorities leave in arrival order.
// Latency and throughput:
//   A request is executed at the edge that accepts it, and its result is
//   shown on the master side in the next cycle. With master tready high, one
//   request per cycle is sustained: the whole insertion or removal is one
//   step of the row of compare-and-shift cells, one cell per entry.
// Reset:
//   Clears the entry count and the result valid; entry contents stay
//   undefined and are never read before being written.
// Stall:
//   A result waits in the output register while the receiver holds tready
//   low; tready on the slave side stays low until that result leaves.
module bounded_priority_queue (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  // [31:0] item_data, [39:32] item_priority
  input  logic [bpq_pkg::IN_TDATA_W-1:0]  s_axis_tdata_i,
  // [0] kind
  input  logic                            s_axis_tuser_i,
  output logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i,
  // [31:0] out_data, [39:32] out_priority, [43:40] occupancy, rest zero
  output logic [bpq_pkg::OUT_TDATA_W-1:0] m_axis_tdata_o,
  // [1:0] status
  output logic [bpq_pkg::STATUS_W-1:0]    m_axis_tuser_o
);
  import bpq_pkg::*;

  cmd_t                cmd;
  stat_t               stat;
  logic [DATA_W-1:0]   res_data;
  logic [PRIO_W-1:0]   res_prio;
  logic [STATUS_W-1:0] res_status;
  logic [OCC_W-1:0]    res_occ;

  // Decide the operation and run the handshakes.
  bpq_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid_i),
    .s_kind_i  (s_axis_tuser_i),
    .s_ready_o (s_axis_tready_o),
    .m_valid_o (m_axis_tvalid_o),
    .m_ready_i (m_axis_tready_i),
    .stat_i    (stat),
    .cmd_o     (cmd)
  );

  // Hold the sorted entries and the result register.
  bpq_datapath u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .in_data_i    (s_axis_tdata_i[DATA_W-1:0]),
    .in_prio_i    (s_axis_tdata_i[DATA_W+PRIO_W-1:DATA_W]),
    .stat_o       (stat),
    .res_data_o   (res_data),
    .res_prio_o   (res_prio),
    .res_status_o (res_status),
    .res_occ_o    (res_occ)
  );

  assign m_axis_tdata_o = {{OUT_PAD_W{1'b0}}, res_occ, res_prio, res_data};
  assign m_axis_tuser_o = res_status;

endmodule

[hw/rtl/bpq_checker.sv]
// Port-level checker for the bounded priority queue, bound to the top level.
module bpq_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            s_axis_tvalid_i,
  input logic                            s_axis_tready_o,
  input logic                            m_axis_tvalid_o,
  input logic                            m_axis_tready_i,
  input logic [bpq_pkg::OUT_TDATA_W-1:0] m_axis_tdata_o,
  input logic [bpq_pkg::STATUS_W-1:0]    m_axis_tuser_o
);
  import bpq_pkg::*;

  logic [OCC_W-1:0] occ;
  assign occ = m_axis_tdata_o[DATA_W+PRIO_W+OCC_W-1:DATA_W+PRIO_W];

  // A stalled result holds its payload.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o))
    else $error("result changed while stalled");

  // An accepted request always yields a result in the next cycle.
  a_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> m_axis_tvalid_o)
    else $error("accepted request without result");

  // Underflow reports an empty store and zero payload.
  a_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (m_axis_tuser_o == ST_UNDERFLOW) |->
      m_axis_tdata_o == '0)
    else $error("underflow result not empty");

  // Overflow only happens at a full store.
  a_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (m_axis_tuser_o == ST_OVERFLOW) |->
      occ == OCC_W'(DEPTH))
    else $error("overflow reported below full");

endmodule

bind bounded_priority_queue bpq_checker u_bpq_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o)
);
